// ===== rtl/sha1_pkg.sv =====
// Shared types, constants and round functions for the SHA-1 byte stream hasher.
// No dependencies.
`default_nettype none
package sha1_pkg;
	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;
	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LengthPos = 6'd56;

	// One queued word between front and back
	typedef struct packed {
		logic       fin;
		logic [7:0] data;
	} item_t;

	// Round constant by round number
	function automatic logic [31:0] round_k(input logic [6:0] r);
		logic [31:0] k;
		if (r < 7'd20) k = 32'h5A827999;
		else if (r < 7'd40) k = 32'h6ED9EBA1;
		else if (r < 7'd60) k = 32'h8F1BBCDC;
		else k = 32'hCA62C1D6;
		return k;
	endfunction

	// Round boolean function
	function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (r < 7'd20) f = (b & c) | (~b & d);
		else if (r < 7'd40) f = b ^ c ^ d;
		else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
		else f = b ^ c ^ d;
		return f;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/sha1_queue.sv =====
// Two-entry queue carrying input words from the front port to the hash engine.
// Depends on sha1_pkg.
`default_nettype none
module sha1_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 valid,
	output logic                stall,
	input  wire                 mode,
	input  wire  [7:0]          data_byte,
	output logic                q_valid,
	input  wire                 q_pop,
	output sha1_pkg::item_t     q_item
);
	sha1_pkg::item_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic push;

	assign stall = (count_q == 2'd2);
	assign push = valid & ~stall;
	assign q_valid = (count_q != 2'd0);
	assign q_item = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{fin: mode, data: data_byte};
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2) |-> stall) else $error("full queue not stalling");
endmodule
`default_nettype wire

// ===== rtl/sha1_engine.sv =====
// Hash engine: byte buffer, message schedule, one round per cycle, digest output.
// Depends on sha1_pkg.
`default_nettype none
module sha1_engine (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 q_valid,
	output logic                q_pop,
	input  sha1_pkg::item_t     q_item,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [31:0]         digest_word,
	output logic [2:0]          word_index,
	output logic                last_word
);
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_LOAD  = 6'b000100,
		ST_ROUND = 6'b001000,
		ST_ADD   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t state_q;
	logic [7:0] buf_q [64];
	logic [5:0] fill_q;
	logic [60:0] total_q;
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w_q [16];
	logic [6:0] round_q;
	logic [6:0] load_q;
	logic fin_q;       // message being finished
	logic extra_q;     // another padding block follows
	logic [2:0] idx_q;
	logic [63:0] bits;
	logic [31:0] w_cur, w_new, t_sum;
	logic buf_we;
	logic [5:0] buf_wa;
	logic [7:0] buf_wd;
	logic [7:0] buf_rd_q;

	assign bits = {total_q, 3'b000};
	assign q_pop = q_valid && (state_q == ST_IDLE);

	// Buffer write source: absorbed byte or padding byte
	always_comb begin
		buf_we = 1'b0;
		buf_wa = fill_q;
		buf_wd = q_item.data;
		if (q_pop) begin
			buf_we = 1'b1;
			buf_wd = q_item.fin ? sha1_pkg::PadByte : q_item.data;
		end else if (state_q == ST_PAD) begin
			buf_we = 1'b1;
			if (fill_q >= sha1_pkg::LengthPos && !extra_q)
				buf_wd = bits[8'(7 - (fill_q - sha1_pkg::LengthPos)) * 8 +: 8];
			else
				buf_wd = 8'h00;
		end
	end

	// Block buffer memory, registered read
	always_ff @(posedge clk) begin
		if (buf_we) buf_q[buf_wa] <= buf_wd;
		buf_rd_q <= buf_q[load_q[5:0]];
	end

	// Schedule word for the current round
	assign w_new = {w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]} << 1
		| {31'b0, (w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31])};
	assign w_cur = (round_q < 7'd16) ? w_q[round_q[3:0]] : w_new;
	assign t_sum = {a_q[26:0], a_q[31:27]} + sha1_pkg::round_f(round_q, b_q, c_q, d_q)
		+ e_q + sha1_pkg::round_k(round_q) + w_cur;

	assign out_valid = (state_q == ST_EMIT);
	assign digest_word = h_q[idx_q];
	assign word_index = idx_q;
	assign last_word = (idx_q == 3'd4);

	// Control and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			total_q <= '0;
			h_q[0] <= sha1_pkg::H0;
			h_q[1] <= sha1_pkg::H1;
			h_q[2] <= sha1_pkg::H2;
			h_q[3] <= sha1_pkg::H3;
			h_q[4] <= sha1_pkg::H4;
			a_q <= '0;
			b_q <= '0;
			c_q <= '0;
			d_q <= '0;
			e_q <= '0;
			for (int i = 0; i < 16; i++) w_q[i] <= '0;
			round_q <= '0;
			load_q <= '0;
			fin_q <= 1'b0;
			extra_q <= 1'b0;
			idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						fill_q <= fill_q + 6'd1;
						load_q <= '0;
						if (!q_item.fin) begin
							total_q <= total_q + 61'd1;
							if (fill_q == 6'd63) state_q <= ST_LOAD;
						end else begin
							fin_q <= 1'b1;
							extra_q <= (fill_q >= 6'd56);
							if (fill_q == 6'd63) state_q <= ST_LOAD;
							else state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						load_q <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					// one read ahead; byte k lands in the cycle after its address
					load_q <= load_q + 7'd1;
					if (load_q != 7'd0) begin
						w_q[15] <= {w_q[15][23:0], buf_rd_q};
						for (int i = 0; i < 15; i++)
							if (load_q[1:0] == 2'd1) w_q[i] <= w_q[i + 1];
					end
					// last byte in; working variables start from the chain
					if (load_q == 7'd64) begin
						a_q <= h_q[0];
						b_q <= h_q[1];
						c_q <= h_q[2];
						d_q <= h_q[3];
						e_q <= h_q[4];
						round_q <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (round_q >= 7'd16) begin
						for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
						w_q[15] <= w_new;
					end
					e_q <= d_q;
					d_q <= c_q;
					c_q <= {b_q[1:0], b_q[31:2]};
					b_q <= a_q;
					a_q <= t_sum;
					round_q <= round_q + 7'd1;
					if (round_q == 7'd79) state_q <= ST_ADD;
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					fill_q <= '0;
					if (!fin_q) state_q <= ST_IDLE;
					else if (extra_q) begin
						extra_q <= 1'b0;
						state_q <= ST_PAD;
					end else begin
						idx_q <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_stall) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd4) begin
							h_q[0] <= sha1_pkg::H0;
							h_q[1] <= sha1_pkg::H1;
							h_q[2] <= sha1_pkg::H2;
							h_q[3] <= sha1_pkg::H3;
							h_q[4] <= sha1_pkg::H4;
							total_q <= '0;
							fin_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> idx_q <= 3'd4) else $error("digest index out of range");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !q_pop) else $error("pop while busy");
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> round_q < 7'd80) else $error("round overrun");
	a_emit_after_add: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_ADD) else $error("bad emit entry");
endmodule
`default_nettype wire

// ===== rtl/sha1_byte_stream_hasher.sv =====
// Top level of the SHA-1 byte stream hasher: input queue feeding the hash engine.
// Depends on sha1_pkg, sha1_queue, sha1_engine.
//
// channel  direction  handshake           payload
// in       input      in_valid/in_stall    mode, data_byte
// out      output     out_valid/out_stall  digest_word, word_index, last_word
//
// Each byte goes into the block buffer; a full block is loaded, run through 80 rounds and added.
// Finish pads one byte per cycle to the block end, compresses once or twice,
// then shows five words, one per cycle that out_stall is low.
// The two-entry queue takes up to two words while the engine compresses.
// arst_n clears control state and restores the initial chaining values.
`default_nettype none
module sha1_byte_stream_hasher (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         mode,
	input  wire  [7:0]  data_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	logic q_valid, q_pop;
	sha1_pkg::item_t q_item;

	sha1_queue u_queue (
		.clk, .arst_n, .valid(in_valid), .stall(in_stall), .mode, .data_byte,
		.q_valid, .q_pop, .q_item
	);

	sha1_engine u_engine (
		.clk, .arst_n, .q_valid, .q_pop, .q_item, .out_valid, .out_stall,
		.digest_word, .word_index, .last_word
	);
endmodule
`default_nettype wire

// ===== tb/sv/sha1_digest_checker.sv =====
// Checker for the SHA-1 byte stream hasher: watches both channels, keeps its own
// SHA-1 state and compares each digest word. Depends on sha1_pkg for the initial values and pad byte.
`timescale 1ns / 1ps
module sha1_digest_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire         mode,
	input  wire  [7:0]  data_byte,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire  [31:0] digest_word,
	input  wire  [2:0]  word_index,
	input  wire         last_word,
	output int          errors,
	output int          pending,
	output int          digests_seen
);
	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_word_t;

	logic [31:0] chain [5];
	logic [7:0]  blk [64];
	int          fill;
	logic [60:0] msg_bytes;
	digest_word_t digest_q[$];

	function automatic logic [31:0] rol(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	task automatic load_iv();
		chain[0] = sha1_pkg::H0; chain[1] = sha1_pkg::H1; chain[2] = sha1_pkg::H2;
		chain[3] = sha1_pkg::H3; chain[4] = sha1_pkg::H4;
	endtask

	// 80-round compression of blk into chain
	task automatic compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int r = 0; r < 16; r++)
			w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
		for (int r = 16; r < 80; r++)
			w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d); k = 32'h5A827999;
			end else if (r < 40) begin
				f = b ^ c ^ d; k = 32'h6ED9EBA1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d; k = 32'hCA62C1D6;
			end
			t = rol(a, 5) + f + e + k + w[r];
			e = d; d = c; c = rol(b, 30); b = a; a = t;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
	endtask

	// Absorb one byte or pad, finish and queue the digest
	task automatic absorb_word(input logic fin, input logic [7:0] byte_in);
		logic [63:0] bits;
		int pos;
		digest_word_t dw;
		if (!fin) begin
			blk[fill] = byte_in;
			msg_bytes = msg_bytes + 61'd1;
			fill++;
			if (fill == 64) begin
				compress();
				fill = 0;
			end
		end else begin
			bits = {msg_bytes, 3'b000};
			pos = fill;
			blk[pos] = sha1_pkg::PadByte;
			pos++;
			if (pos > 56) begin
				while (pos < 64) begin
					blk[pos] = 8'h00;
					pos++;
				end
				compress();
				pos = 0;
			end
			while (pos < 56) begin
				blk[pos] = 8'h00;
				pos++;
			end
			for (int i = 0; i < 8; i++) blk[56+i] = bits[(7-i)*8 +: 8];
			compress();
			for (int i = 0; i < 5; i++) begin
				dw.word = chain[i]; dw.idx = 3'(i); dw.last = (i == 4);
				digest_q.push_back(dw);
			end
			load_iv();
			fill = 0;
			msg_bytes = '0;
		end
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		errors++;
	endtask

	initial begin
		errors = 0; pending = 0; digests_seen = 0; fill = 0; msg_bytes = '0;
		load_iv();
	end

	always @(posedge clk) begin
		digest_word_t exp_w;
		if (arst_n) begin
			if (in_valid && !in_stall) absorb_word(mode, data_byte);
			if (out_valid && !out_stall) begin
				if (digest_q.size() == 0) begin
					report("unexpected word", digest_word, 32'h0);
				end else begin
					exp_w = digest_q.pop_front();
					if (digest_word !== exp_w.word) report("digest_word", digest_word, exp_w.word);
					if (word_index !== exp_w.idx) report("word_index", 32'(word_index), 32'(exp_w.idx));
					if (last_word !== exp_w.last) report("last_word", 32'(last_word), 32'(exp_w.last));
					if (exp_w.last) digests_seen++;
				end
			end
			pending = digest_q.size();
		end
	end
endmodule

// ===== tb/sv/tb_sha1_byte_stream_hasher.sv =====
// Top of the SHA-1 byte stream hasher testbench: clock, reset, stimulus and verdict.
// Depends on sha1_byte_stream_hasher and sha1_digest_checker.
`timescale 1ns / 1ps
module tb_sha1_byte_stream_hasher;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        mode = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        out_stall = 1'b0;
	logic        in_stall, out_valid, last_word;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	int          errors, pending, digests_seen;
	int          words_sent = 0;
	bit          quiet = 1'b0;

	always #1 clk = ~clk;

	sha1_byte_stream_hasher uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .data_byte(data_byte), .out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	sha1_digest_checker chk (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .data_byte(data_byte), .out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word),
		.errors(errors), .pending(pending), .digests_seen(digests_seen)
	);

	// Present one word and hold it until accepted, with an occasional random gap before it;
	// valid stays high after acceptance unless a gap follows
	task automatic send_word(input logic fin, input logic [7:0] b);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= fin;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) send_word(1'b0, 8'($urandom));
		send_word(1'b1, 8'($urandom));
	endtask

	// Receiver stalls in bursts
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#2000000;
		$display("tb_sha1_byte_stream_hasher: FAIL");
		$finish;
	end

	initial begin
		int len;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: empty message, extreme bytes
		send_word(1'b1, 8'hFF);
		send_word(1'b0, 8'h00); send_word(1'b0, 8'hFF); send_word(1'b1, 8'h00);
		send_word(1'b0, 8'hAA); send_word(1'b0, 8'h55); send_word(1'b1, 8'h5A);
		// Hold off until every digest word is out
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// Pad spilling into an extra block, and a finish right after a full block
		send_message(56);
		send_message(64);
		// Random short messages
		while (words_sent < 150) begin
			if (words_sent > 130) quiet = 1'b1;
			len = $urandom_range(0, 12);
			send_message(len);
		end
		quiet = 1'b1;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("covered %0d input words and %0d digests, incl. empty and block-edge lengths",
			words_sent, digests_seen);
		if (errors == 0)
			$display("tb_sha1_byte_stream_hasher: PASS");
		else
			$display("tb_sha1_byte_stream_hasher: FAIL");
		$finish;
	end
endmodule
